// File: design/mprc_pkg.sv
// Shared types, constants and the byte-wide CRC-16 update for the
// Modbus position reply checker. No dependencies.
`default_nettype none

package mprc_pkg;

  localparam int unsigned BUFFER_BYTES_DEF = 16;

  localparam int unsigned CountW  = 5;
  localparam int unsigned CrcW    = 16;
  localparam int unsigned PosW    = 32;
  localparam int unsigned StatusW = 2;

  localparam logic [CrcW-1:0]   CrcPoly    = 16'hA001;
  localparam logic [CrcW-1:0]   CrcInit    = 16'hFFFF;
  localparam logic [CountW-1:0] GoodLength = 5'd9;
  localparam logic [CountW-1:0] CrcSpan    = 5'd7;
  localparam logic [CountW-1:0] PayFirst   = 5'd3;
  localparam logic [CountW-1:0] PayLast    = 5'd6;
  localparam logic [CountW-1:0] CrcLoIdx   = 5'd7;
  localparam logic [CountW-1:0] CrcHiIdx   = 5'd8;

  // tdata of the result side: status, position, zero fill to whole bytes
  localparam int unsigned OutDataW = ((StatusW + PosW + 7) / 8) * 8;

  typedef enum logic [StatusW-1:0] {
    ST_OK  = 2'd0,
    ST_LEN = 2'd1,
    ST_CRC = 2'd2
  } status_e;

  typedef enum logic {
    CMD_BYTE = 1'b0,
    CMD_IDLE = 1'b1
  } cmd_e;

  // One registered input beat
  typedef struct packed {
    cmd_e       cmd;
    logic [7:0] data;
  } beat_t;

  // Reflected CRC-16, one byte, eight shift steps
  function automatic logic [CrcW-1:0] crc_byte(input logic [CrcW-1:0] crc,
                                               input logic [7:0]      b);
    logic [CrcW-1:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CrcPoly;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// File: design/mprc_in_reg.sv
// Input register stage: holds one beat from the stream input.
// Depends on mprc_pkg.
`default_nettype none

module mprc_in_reg
  import mprc_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  valid_i,
  output logic       ready_o,
  input  wire beat_t beat_i,
  output logic       valid_o,
  input  wire logic  take_i,   // downstream consumes the held beat
  output beat_t      beat_o
);

  logic  valid_q, valid_d;
  beat_t beat_q;

  assign ready_o = !valid_q || take_i;
  assign valid_d = (valid_i && ready_o) || (valid_q && !take_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      beat_q <= beat_i;
    end
  end

  assign valid_o = valid_q;
  assign beat_o  = beat_q;

endmodule

`default_nettype wire

// File: design/mprc_frame.sv
// Frame tracker: byte count, running CRC, payload capture, frame-end status
// and the result register. Depends on mprc_pkg.
`default_nettype none

module mprc_frame
  import mprc_pkg::*;
#(
  parameter int unsigned BUFFER_BYTES = BUFFER_BYTES_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        valid_i,
  input  wire beat_t       beat_i,
  output logic             take_o,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output status_e          status_o,
  output logic [PosW-1:0]  position_o
);

  localparam logic [CountW-1:0] BufLimit = CountW'(BUFFER_BYTES);

  logic [CountW-1:0] count_q, count_d, count_inc;
  logic [CrcW-1:0]   crc_q, crc_d;
  logic [PosW-1:0]   pay_q, pay_d;
  logic [CrcW-1:0]   rcrc_q, rcrc_d;
  logic [PosW-1:0]   held_q, held_d;
  logic              out_valid_q, out_valid_d;
  status_e           status_q, status_d;
  logic [PosW-1:0]   pos_q;
  logic              fire, frame_end;
  logic [CrcW-1:0]   crc_upd;
  logic [PosW-1:0]   pay_upd;
  logic [CrcW-1:0]   rcrc_upd;

  assign take_o = !out_valid_q || out_ready_i;
  assign fire   = valid_i && take_o;

  // Byte path
  assign count_inc = count_q + 1'b1;
  assign crc_upd   = (count_q < CrcSpan) ? crc_byte(crc_q, beat_i.data) : crc_q;

  always_comb begin
    pay_upd  = pay_q;
    rcrc_upd = rcrc_q;
    if (count_q >= PayFirst && count_q <= PayLast) begin
      pay_upd = {pay_q[PosW-9:0], beat_i.data};
    end else if (count_q == CrcLoIdx) begin
      rcrc_upd = {rcrc_q[15:8], beat_i.data};
    end else if (count_q == CrcHiIdx) begin
      rcrc_upd = {beat_i.data, rcrc_q[7:0]};
    end
  end

  assign frame_end = (beat_i.cmd == CMD_IDLE) || (count_inc >= BufLimit);

  always_comb begin
    logic [CountW-1:0] len;
    logic [CrcW-1:0]   crc_fin;
    logic [CrcW-1:0]   rcrc_fin;
    logic [PosW-1:0]   pay_fin;
    len      = (beat_i.cmd == CMD_IDLE) ? count_q : count_inc;
    crc_fin  = (beat_i.cmd == CMD_IDLE) ? crc_q   : crc_upd;
    rcrc_fin = (beat_i.cmd == CMD_IDLE) ? rcrc_q  : rcrc_upd;
    pay_fin  = (beat_i.cmd == CMD_IDLE) ? pay_q   : pay_upd;

    count_d     = count_q;
    crc_d       = crc_q;
    pay_d       = pay_q;
    rcrc_d      = rcrc_q;
    held_d      = held_q;
    status_d    = ST_OK;
    out_valid_d = out_valid_q && !out_ready_i;

    if (fire) begin
      if (frame_end) begin
        if (len != GoodLength) begin
          status_d = ST_LEN;
        end else if (rcrc_fin != crc_fin) begin
          status_d = ST_CRC;
        end else begin
          status_d = ST_OK;
          held_d   = pay_fin;
        end
        out_valid_d = 1'b1;
        count_d     = '0;
        crc_d       = CrcInit;
        pay_d       = '0;
        rcrc_d      = '0;
      end else begin
        count_d = count_inc;
        crc_d   = crc_upd;
        pay_d   = pay_upd;
        rcrc_d  = rcrc_upd;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      crc_q       <= CrcInit;
      pay_q       <= '0;
      rcrc_q      <= '0;
      held_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      crc_q       <= crc_d;
      pay_q       <= pay_d;
      rcrc_q      <= rcrc_d;
      held_q      <= held_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Result payload loads only with a new result
  always_ff @(posedge clk_i) begin
    if (fire && frame_end) begin
      status_q <= status_d;
      pos_q    <= held_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign position_o  = pos_q;

`ifndef NO_ASSERTIONS
  a_count_below_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q < BufLimit)
    else $error("byte count reached buffer size without frame end");

  a_clear_after_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && frame_end |=> count_q == '0 && crc_q == CrcInit)
    else $error("frame state not cleared after frame end");

  a_ok_matches_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && status_q == ST_OK |-> pos_q == held_q)
    else $error("accepted result position differs from held position");

  a_no_fire_when_blocked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_ready_i |-> !fire)
    else $error("beat consumed while result register blocked");
`endif

endmodule

`default_nettype wire

// File: design/modbus_position_reply_checker.sv
// Modbus RTU position reply checker, top level: input register and frame
// tracker. Depends on mprc_pkg, mprc_in_reg, mprc_frame.
//
// Usage:
//   Input stream: one beat per received serial byte (tuser = 0, tdata = byte)
//   or per idle-line event (tuser = 1, tdata ignored) that closes the frame.
//   A frame also closes on the byte that fills BUFFER_BYTES.
//   Output stream: one beat per closed frame with status (0 accepted,
//   1 wrong length, 2 CRC mismatch) and the last accepted position.
//   The report for a closing beat passes the input register, then the result
//   register, before it is valid on the output.
//   Throughput: one beat per cycle while the output is not stalled, set by the
//   single byte-wide CRC update between the input and result registers.
//   Stall: while the output is held and not taken, the frame tracker stops
//   and the input register holds one beat; tready drops once it is full.
//   Reset: empty frame, CRC 0xFFFF, held position zero, both stages empty.
`default_nettype none

module modbus_position_reply_checker
  import mprc_pkg::*;
#(
  parameter int unsigned BUFFER_BYTES = BUFFER_BYTES_DEF
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                s_axis_tvalid_i,
  output logic                     s_axis_tready_o,
  input  wire logic [7:0]          s_axis_tdata_i,  // [7:0] data_byte
  input  wire logic                s_axis_tuser_i,  // [0] cmd
  output logic                     m_axis_tvalid_o,
  input  wire logic                m_axis_tready_i,
  output logic [OutDataW-1:0]      m_axis_tdata_o   // [1:0] status, [33:2] position
);

  beat_t           in_beat, held_beat;
  logic            held_valid, take;
  status_e         status;
  logic [PosW-1:0] position;

  assign in_beat.cmd  = cmd_e'(s_axis_tuser_i);
  assign in_beat.data = s_axis_tdata_i;

  mprc_in_reg u_in_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid_i),
    .ready_o (s_axis_tready_o),
    .beat_i  (in_beat),
    .valid_o (held_valid),
    .take_i  (take),
    .beat_o  (held_beat)
  );

  mprc_frame #(
    .BUFFER_BYTES (BUFFER_BYTES)
  ) u_frame (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (held_valid),
    .beat_i      (held_beat),
    .take_o      (take),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .status_o    (status),
    .position_o  (position)
  );

  assign m_axis_tdata_o = {{(OutDataW - StatusW - PosW){1'b0}}, position, status};

endmodule

`default_nettype wire
